// ===== rtl/ip_flow_table_with_aging_macros.svh =====
// assertion macros shared by the checker
`ifndef IP_FLOW_TABLE_WITH_AGING_MACROS_SVH
`define IP_FLOW_TABLE_WITH_AGING_MACROS_SVH

// an implication checked on every clock edge outside reset
`define FT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// an implication whose consequent is checked in the next cycle
`define FT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ftab_pkg.sv =====
// ----------------------------------------------------------------------------
// ftab_pkg
// shared types and constants of the flow table with aging
// ----------------------------------------------------------------------------
package ftab_pkg;

  localparam int unsigned FLOW_SLOTS_DEF = 32;

  localparam logic [1:0] EV_DELETED   = 2'd0;
  localparam logic [1:0] EV_CREATED   = 2'd1;
  localparam logic [1:0] EV_PROCESSED = 2'd2;

  localparam logic [1:0] REG_HALF_TO  = 2'd0;
  localparam logic [1:0] REG_FULL_TO  = 2'd1;
  localparam logic [1:0] REG_CHECK    = 2'd2;
  // index with no register behind it, writes are ignored
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  localparam logic [31:0] HALF_TO_RST = 32'd300;
  localparam logic [31:0] FULL_TO_RST = 32'd3600;
  localparam logic [31:0] CHECK_RST   = 32'd1;

  // entry as stored in the table ram: full, dst, src, seen
  typedef struct packed {
    logic        full;
    logic [31:0] dst;
    logic [31:0] src;
    logic [31:0] seen;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWP_RD,
    ST_SWP_CHK,
    ST_SWP_EMIT,
    ST_LK_RD,
    ST_LK_CHK,
    ST_DECIDE,
    ST_RV_RD,
    ST_RV_WR,
    ST_FW_RD,
    ST_FW_WR,
    ST_EMIT_CR,
    ST_EMIT_PR
  } state_t;

  // true when now - then >= span without wrap
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] then_t,
                                   input logic [31:0] span);
    logic [31:0] diff;
    diff = now - then_t;
    return (now >= then_t) && (diff >= span);
  endfunction

endpackage

// ===== rtl/ftab_ram.sv =====
// ----------------------------------------------------------------------------
// ftab_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ftab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/ip_flow_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// ip_flow_table_with_aging
// flow table keyed by address pair with idle timeout sweeps
// ----------------------------------------------------------------------------
// One packet is handled at a time; in_stall is high while the block is busy.
// Entries live in a single-port ram with a registered read; valid bits are
// flip-flops. An aging sweep, when due, reads every slot (a read state and a
// check state per slot) and closes the walk in an emit state; each deleted
// event is held back until the next deletion or the end of the walk so that
// its last-event flag is known, and the walk only waits while the output
// register is stalled. An IP packet then walks all slots once, matching the
// forward and reverse keys and the lowest free slot, followed by a decision,
// read-modify-write of the reverse and forward entries and the created and
// processed events. A non-IP packet with no sweep due leaves the block idle.
// Results wait in an output register.
module ip_flow_table_with_aging #(
  parameter int unsigned FLOW_SLOTS = ftab_pkg::FLOW_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_time_sec,
  input  logic        in_has_ip,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_flow_src,
  output logic [31:0] out_flow_dst,
  output logic        out_flow_full,
  output logic        out_table_full,
  output logic        out_last_event
);
  import ftab_pkg::*;

  localparam int unsigned AW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int unsigned CW = $clog2(FLOW_SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(FLOW_SLOTS - 1);

  // configuration registers
  logic [31:0] half_to_r, full_to_r, check_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_to_r <= HALF_TO_RST;
      full_to_r <= FULL_TO_RST;
      check_r   <= CHECK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_TO: half_to_r <= cfg_data;
        REG_FULL_TO: full_to_r <= cfg_data;
        REG_CHECK:   check_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // table ram and valid bits
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  entry_t          ram_wdata, ram_rdata;
  logic [FLOW_SLOTS-1:0] valid_r, valid_nxt;

  ftab_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  state_t state_r, state_nxt;
  logic [31:0] now_r, src_r, dst_r, last_sweep_r, last_sweep_nxt;
  logic        ip_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic        fw_hit_r, rv_hit_r, free_hit_r;
  logic [AW-1:0] fw_r, rv_r, free_r;
  logic        fw_hit_nxt, rv_hit_nxt, free_hit_nxt;
  logic [AW-1:0] fw_nxt, rv_nxt, free_nxt;
  logic        full_now_r, full_now_nxt, drop_r, drop_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [31:0] os_r, os_nxt, od_r, od_nxt;
  logic        of_r, of_nxt, otf_r, otf_nxt, ol_r, ol_nxt;
  logic        pend_r, pend_nxt;
  entry_t      pend_e_r, pend_e_nxt;
  logic [AW-1:0] idx_a;
  logic        out_free, sw_due, age_hit, swp_go;

  assign idx_a    = idx_r[AW-1:0];
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign sw_due   = (check_r != 32'd0) && elapsed(in_time_sec, last_sweep_r, check_r);
  assign age_hit  = valid_r[idx_a] &&
                    elapsed(now_r, ram_rdata.seen, ram_rdata.full ? full_to_r : half_to_r);
  // a new deletion can only be taken once the held one has left
  assign swp_go   = !(age_hit && pend_r && !out_free);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      last_sweep_r <= '0;
      ov_r         <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      last_sweep_r <= last_sweep_nxt;
      ov_r         <= ov_nxt;
      pend_r       <= pend_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      now_r <= in_time_sec;
      src_r <= in_src_addr;
      dst_r <= in_dst_addr;
      ip_r  <= in_has_ip;
    end
    idx_r      <= idx_nxt;
    fw_hit_r   <= fw_hit_nxt;
    rv_hit_r   <= rv_hit_nxt;
    free_hit_r <= free_hit_nxt;
    fw_r       <= fw_nxt;
    rv_r       <= rv_nxt;
    free_r     <= free_nxt;
    full_now_r <= full_now_nxt;
    drop_r     <= drop_nxt;
    pend_e_r   <= pend_e_nxt;
    ok_r       <= ok_nxt;
    os_r       <= os_nxt;
    od_r       <= od_nxt;
    of_r       <= of_nxt;
    otf_r      <= otf_nxt;
    ol_r       <= ol_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sw_due)         state_nxt = ST_SWP_RD;
          else if (in_has_ip) state_nxt = ST_LK_RD;
        end
      end
      ST_SWP_RD:   state_nxt = ST_SWP_CHK;
      ST_SWP_CHK: begin
        if (swp_go) state_nxt = (idx_r == LAST) ? ST_SWP_EMIT : ST_SWP_RD;
      end
      ST_SWP_EMIT: begin
        if (!pend_r || out_free) state_nxt = ip_r ? ST_LK_RD : ST_IDLE;
      end
      ST_LK_RD:    state_nxt = ST_LK_CHK;
      ST_LK_CHK:   state_nxt = (idx_r == LAST) ? ST_DECIDE : ST_LK_RD;
      ST_DECIDE: begin
        if (fw_hit_r)         state_nxt = ST_FW_RD;
        else if (!free_hit_r) state_nxt = ST_EMIT_PR;
        else if (rv_hit_r)    state_nxt = ST_RV_RD;
        else                  state_nxt = ST_FW_WR;
      end
      ST_RV_RD:    state_nxt = ST_RV_WR;
      ST_RV_WR:    state_nxt = ST_FW_WR;
      ST_FW_RD:    state_nxt = ST_FW_WR;
      ST_FW_WR:    state_nxt = fw_hit_r ? ST_EMIT_PR : ST_EMIT_CR;
      ST_EMIT_CR:  if (out_free) state_nxt = ST_EMIT_PR;
      ST_EMIT_PR:  if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ram_we = 1'b0; ram_addr = idx_a; ram_wdata = ram_rdata;
    valid_nxt = valid_r; last_sweep_nxt = last_sweep_r;
    idx_nxt = idx_r;
    fw_hit_nxt = fw_hit_r; rv_hit_nxt = rv_hit_r; free_hit_nxt = free_hit_r;
    fw_nxt = fw_r; rv_nxt = rv_r; free_nxt = free_r;
    full_now_nxt = full_now_r; drop_nxt = drop_r;
    pend_nxt = pend_r; pend_e_nxt = pend_e_r;
    ov_nxt = ov_r && out_stall;
    ok_nxt = ok_r; os_nxt = os_r; od_nxt = od_r; of_nxt = of_r;
    otf_nxt = otf_r; ol_nxt = ol_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0; fw_hit_nxt = 1'b0; rv_hit_nxt = 1'b0; free_hit_nxt = 1'b0;
        drop_nxt = 1'b0; pend_nxt = 1'b0;
        if (in_valid && sw_due) last_sweep_nxt = in_time_sec;
      end
      ST_SWP_RD: ;
      ST_SWP_CHK: begin
        // aged entry: release the held deletion, hold this one
        if (swp_go) begin
          if (age_hit) begin
            valid_nxt[idx_a] = 1'b0;
            pend_nxt = 1'b1; pend_e_nxt = ram_rdata;
            if (pend_r) begin
              ov_nxt = 1'b1; ok_nxt = EV_DELETED; os_nxt = pend_e_r.src;
              od_nxt = pend_e_r.dst; of_nxt = pend_e_r.full; otf_nxt = 1'b0;
              ol_nxt = 1'b0;
            end
          end
          idx_nxt = (idx_r == LAST) ? '0 : idx_r + CW'(1);
        end
      end
      ST_SWP_EMIT: begin
        // last held deletion closes the transaction when no lookup follows
        if (pend_r && out_free) begin
          ov_nxt = 1'b1; ok_nxt = EV_DELETED; os_nxt = pend_e_r.src;
          od_nxt = pend_e_r.dst; of_nxt = pend_e_r.full; otf_nxt = 1'b0;
          ol_nxt = !ip_r; pend_nxt = 1'b0;
        end
      end
      ST_LK_RD: ;
      ST_LK_CHK: begin
        if (valid_r[idx_a]) begin
          if (!fw_hit_r && ram_rdata.src == src_r && ram_rdata.dst == dst_r) begin
            fw_hit_nxt = 1'b1; fw_nxt = idx_a;
          end
          if (!rv_hit_r && ram_rdata.src == dst_r && ram_rdata.dst == src_r) begin
            rv_hit_nxt = 1'b1; rv_nxt = idx_a;
          end
        end else if (!free_hit_r) begin
          free_hit_nxt = 1'b1; free_nxt = idx_a;
        end
        idx_nxt = idx_r + CW'(1);
      end
      ST_DECIDE: begin
        if (!fw_hit_r) begin
          if (!free_hit_r) begin
            drop_nxt = 1'b1; full_now_nxt = 1'b0;
          end else begin
            fw_nxt = free_r;
            full_now_nxt = rv_hit_r;
          end
        end
        ram_addr = fw_hit_r ? fw_r : rv_r;
      end
      ST_RV_RD: ram_addr = rv_r;
      ST_RV_WR: begin
        ram_addr = rv_r; ram_we = 1'b1;
        ram_wdata = ram_rdata; ram_wdata.full = 1'b1;
      end
      ST_FW_RD: ram_addr = fw_r;
      ST_FW_WR: begin
        ram_addr = fw_r; ram_we = 1'b1;
        if (fw_hit_r) begin
          ram_wdata = ram_rdata; ram_wdata.seen = now_r;
          full_now_nxt = ram_rdata.full;
        end else begin
          ram_wdata.full = rv_hit_r; ram_wdata.src = src_r;
          ram_wdata.dst = dst_r; ram_wdata.seen = now_r;
          valid_nxt[fw_r] = 1'b1;
        end
      end
      ST_EMIT_CR: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = EV_CREATED; os_nxt = src_r; od_nxt = dst_r;
          of_nxt = 1'b0; otf_nxt = 1'b0; ol_nxt = 1'b0;
        end
      end
      ST_EMIT_PR: begin
        if (out_free) begin
          ov_nxt = 1'b1; ok_nxt = EV_PROCESSED; os_nxt = src_r; od_nxt = dst_r;
          of_nxt = full_now_r; otf_nxt = drop_r; ol_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_event_kind = ok_r;
  assign out_flow_src   = os_r;
  assign out_flow_dst   = od_r;
  assign out_flow_full  = of_r;
  assign out_table_full = otf_r;
  assign out_last_event = ol_r;

endmodule

// ===== rtl/ftab_checker.sv =====
// ----------------------------------------------------------------------------
// ftab_checker
// port level checks of the flow table, bound to the top level
// ----------------------------------------------------------------------------
`include "ip_flow_table_with_aging_macros.svh"
module ftab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_kind,
  input logic        out_table_full,
  input logic        out_flow_full,
  input logic        out_last_event
);
  import ftab_pkg::*;

  // stalled result stays up
  `FT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // kind is never the unused code
  `FT_ASSERT_IMP(a_kind, clk, rst_n, out_valid,
    out_event_kind == EV_DELETED || out_event_kind == EV_CREATED ||
    out_event_kind == EV_PROCESSED)
  // table full only on a processed event, with a half flow
  `FT_ASSERT_IMP(a_tfull, clk, rst_n, out_valid && out_table_full,
    out_event_kind == EV_PROCESSED && !out_flow_full)
  // processed event always closes the transaction
  `FT_ASSERT_IMP(a_last, clk, rst_n, out_valid && out_event_kind == EV_PROCESSED,
    out_last_event)
endmodule

bind ip_flow_table_with_aging ftab_checker u_ftab_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_event_kind(out_event_kind),
  .out_table_full(out_table_full), .out_flow_full(out_flow_full),
  .out_last_event(out_last_event)
);

// ===== bench/tb_ip_flow_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// tb_ip_flow_table_with_aging
// self-checking bench for the flow table with idle-timeout aging
// ----------------------------------------------------------------------------
// Packet records go in through a valid/stall sender. A model of the table in
// the bench predicts the deleted, created and processed events of each one.
// A checker compares every event with the oldest prediction, field by field.
// The bench runs directed cases first, then random traffic over a few
// register settings, with random gaps and stalls on both sides.
`timescale 1ns / 1ps

module tb_ip_flow_table_with_aging;
  import ftab_pkg::*;

  localparam int SLOTS = 32;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] src;
    logic [31:0] dst;
    logic        full;
    logic        tfull;
    logic        last;
  } flow_event_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_time_sec;
  logic        in_has_ip;
  logic [31:0] in_src_addr;
  logic [31:0] in_dst_addr;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_event_kind;
  logic [31:0] out_flow_src;
  logic [31:0] out_flow_dst;
  logic        out_flow_full;
  logic        out_table_full;
  logic        out_last_event;

  // table model
  logic [31:0] half_to, full_to, sweep_every;
  logic        tbl_valid [SLOTS];
  logic [31:0] tbl_src [SLOTS];
  logic [31:0] tbl_dst [SLOTS];
  logic        tbl_full [SLOTS];
  logic [31:0] tbl_seen [SLOTS];
  logic [31:0] last_sweep;

  flow_event_t pending_events[$];
  int          error_count;
  int          event_count;
  int          packet_count;
  int          idle_cycles;
  bit          hold_off;
  logic [31:0] clock_sec;

  ip_flow_table_with_aging u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit aged(logic [31:0] now, logic [31:0] then_t, logic [31:0] span);
    return now >= then_t && (now - then_t) >= span;
  endfunction

  function automatic int find_flow(logic [31:0] s, logic [31:0] d);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_src[i] == s && tbl_dst[i] == d) return i;
    return -1;
  endfunction

  function automatic void push_event(logic [1:0] k, logic [31:0] s, logic [31:0] d,
                                     logic f, logic t);
    flow_event_t e;
    e.kind = k; e.src = s; e.dst = d; e.full = f; e.tfull = t; e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  // predict the events of one packet
  function automatic void predict_packet(logic [31:0] now, logic ip, logic [31:0] s,
                                         logic [31:0] d);
    int n0, fw, rv;
    logic dropped, full_now;
    n0 = pending_events.size();
    if (sweep_every != 0 && aged(now, last_sweep, sweep_every)) begin
      for (int i = 0; i < SLOTS; i++)
        if (tbl_valid[i] && aged(now, tbl_seen[i], tbl_full[i] ? full_to : half_to)) begin
          push_event(EV_DELETED, tbl_src[i], tbl_dst[i], tbl_full[i], 1'b0);
          tbl_valid[i] = 1'b0;
        end
      last_sweep = now;
    end
    if (ip) begin
      fw = find_flow(s, d);
      rv = find_flow(d, s);
      dropped = 1'b0;
      full_now = 1'b0;
      if (fw < 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (!tbl_valid[i]) begin fw = i; break; end
        if (fw < 0) dropped = 1'b1;
        else begin
          tbl_valid[fw] = 1'b1; tbl_src[fw] = s; tbl_dst[fw] = d; tbl_full[fw] = 1'b0;
          push_event(EV_CREATED, s, d, 1'b0, 1'b0);
          if (rv >= 0) begin
            tbl_full[fw] = 1'b1;
            tbl_full[rv] = 1'b1;
          end
        end
      end
      if (!dropped) begin
        tbl_seen[fw] = now;
        full_now = tbl_full[fw];
      end
      push_event(EV_PROCESSED, s, d, full_now, dropped);
    end
    if (pending_events.size() > n0) pending_events[$].last = 1'b1;
  endfunction

  // send one packet record
  task automatic send_packet(logic [31:0] t, logic ip, logic [31:0] s, logic [31:0] d);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1; in_time_sec = t; in_has_ip = ip; in_src_addr = s; in_dst_addr = d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_packet(t, ip, s, d);
    packet_count++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_HALF_TO: half_to = val;
      REG_FULL_TO: full_to = val;
      REG_CHECK:   sweep_every = val;
      default: ;
    endcase
  endtask

  // random address from a small pool so flows repeat and reverse
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return 32'h0a00_0000 | $urandom_range(0, 7);
  endfunction

  // checker: compare each accepted event with the oldest prediction
  always @(posedge clk) begin
    flow_event_t e;
    if (rst_n && out_valid && !out_stall) begin
      event_count++;
      if (pending_events.size() == 0) begin
        $error("unexpected event kind %0d src %h", out_event_kind, out_flow_src);
        error_count++;
      end else begin
        e = pending_events.pop_front();
        if (out_event_kind !== e.kind) begin
          $error("event_kind expected %0d actual %0d", e.kind, out_event_kind);
          error_count++;
        end
        if (out_flow_src !== e.src) begin
          $error("flow_src expected %h actual %h", e.src, out_flow_src);
          error_count++;
        end
        if (out_flow_dst !== e.dst) begin
          $error("flow_dst expected %h actual %h", e.dst, out_flow_dst);
          error_count++;
        end
        if (out_flow_full !== e.full) begin
          $error("flow_full expected %0d actual %0d", e.full, out_flow_full);
          error_count++;
        end
        if (out_table_full !== e.tfull) begin
          $error("table_full expected %0d actual %0d", e.tfull, out_table_full);
          error_count++;
        end
        if (out_last_event !== e.last) begin
          $error("last_event expected %0d actual %0d", e.last, out_last_event);
          error_count++;
        end
      end
    end
  end

  // receiver stall: random per transaction, or a long hold-off
  initial begin
    int wait_n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
        out_stall = 1'b0;
      end else if (out_valid && !out_stall) begin
        wait_n = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) wait_n = 0;
        if (wait_n != 0) begin
          out_stall = 1'b1;
          repeat (wait_n) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    send_packet(32'd0, 1'b1, 32'h0000_0000, 32'hffff_ffff);
    send_packet(32'd0, 1'b1, 32'hffff_ffff, 32'h0000_0000);
    send_packet(32'd1, 1'b1, 32'h0000_0000, 32'hffff_ffff);
    send_packet(32'd2, 1'b1, 32'h1234_5678, 32'h1234_5678);
    send_packet(32'd2, 1'b0, 32'hdead_beef, 32'h0bad_f00d);
    send_packet(32'd1, 1'b1, 32'h0000_0001, 32'h0000_0002);
    send_packet(32'd400, 1'b0, 32'h5555_5555, 32'haaaa_aaaa);
    send_packet(32'd300, 1'b1, 32'haaaa_aaaa, 32'h5555_5555);
    send_packet(32'd5000, 1'b1, 32'h0000_0002, 32'h0000_0001);
    send_packet(32'hffff_ffff, 1'b0, 32'h0, 32'h0);
    send_packet(32'hffff_fff0, 1'b1, 32'h1, 32'h2);
  endtask

  // fill the table and go past it to reach the dropped insert
  task automatic test_table_full();
    write_reg(REG_CHECK, 32'd0);
    for (int i = 0; i < SLOTS + 3; i++)
      send_packet(32'd10, 1'b1, 32'hc000_0000 + i, 32'hc100_0000);
    send_packet(32'd11, 1'b1, 32'hc100_0000, 32'hc000_0001);
    wait_drained();
    write_reg(REG_HALF_TO, 32'd0);
    write_reg(REG_CHECK, 32'hffff_ffff);
    send_packet(32'hffff_ffff, 1'b1, 32'h7, 32'h8);
    wait_drained();
  endtask

  task automatic test_random(int count, logic [31:0] h, logic [31:0] f, logic [31:0] c);
    write_reg(REG_HALF_TO, h);
    write_reg(REG_FULL_TO, f);
    write_reg(REG_CHECK, c);
    write_reg(REG_UNUSED, $urandom());
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) clock_sec = clock_sec - $urandom_range(0, 20);
      else if ($urandom_range(0, 19) == 0) clock_sec = $urandom();
      else clock_sec = clock_sec + $urandom_range(0, 6);
      send_packet(clock_sec, $urandom_range(0, 5) != 0, pick_addr(), pick_addr());
    end
    wait_drained();
  endtask

  // receiver holds off while packets keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_packet(clock_sec + i, 1'b1, pick_addr(), pick_addr());
    clock_sec = clock_sec + 12;
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = REG_HALF_TO; cfg_data = '0;
    in_valid = 1'b0; in_time_sec = '0; in_has_ip = 1'b0; in_src_addr = '0; in_dst_addr = '0;
    hold_off = 1'b0; error_count = 0; event_count = 0; packet_count = 0; idle_cycles = 0;
    clock_sec = 32'd100;
    half_to = HALF_TO_RST; full_to = FULL_TO_RST; sweep_every = CHECK_RST; last_sweep = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0; tbl_src[i] = '0; tbl_dst[i] = '0; tbl_full[i] = 1'b0; tbl_seen[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    wait_drained();
    test_table_full();
    test_random(55, 32'd8, 32'd20, 32'd1);
    test_backpressure();
    test_random(45, 32'd3, 32'd5, 32'd2);
    test_random(40, 32'hffff_ffff, 32'h0, 32'd0);
    test_random(30, 32'd0, 32'hffff_ffff, 32'd4);
    $display("summary: %0d packets sent, %0d events checked", packet_count, event_count);
    $display("covered aging, table overflow, reverse flows, stalls and time wrap");
    if (error_count == 0 && pending_events.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
